@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted.
`define CORDIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cordic checker: property violated");

// Concurrent assertion that is also checked during reset.
`define CORDIC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cordic checker: property violated during reset");

`endif

@@ hdl/cordic_pkg.sv @@
// Types, constants and the arctangent table of the CORDIC pipeline.
package cordic_pkg;

  // Datapath widths
  localparam int XY_W   = 20;   // x and y words, 16-bit input plus growth
  localparam int IN_W   = 16;   // x_in and y_in
  localparam int ANG_W  = 22;   // angle accumulator
  localparam int AIN_W  = 21;   // angle_in
  localparam int RES_W  = 22;   // result
  localparam int FRAC_W = 12;   // Q.12 fraction
  localparam int GAIN_W = 13;   // signed width of the gain constant
  localparam int PROD_W = XY_W + GAIN_W;
  localparam int TAB_W  = 4;    // table index
  localparam int TAB_LEN = 16;  // entries in the arctangent table
  localparam logic signed [GAIN_W-1:0] GAIN_Q12 = 13'sd2487;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ROTATE = 2'd0,
    CMD_ATAN   = 2'd1,
    CMD_SIN    = 2'd2,
    CMD_COS    = 2'd3
  } cmd_e;

  // One word travelling down the pipeline
  typedef struct packed {
    cmd_e                    cmd;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
  } cordic_word_t;

  // atan(2^-i) in degrees, Q.12
  function automatic logic signed [ANG_W-1:0] atan_q12(input logic [TAB_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    unique case (idx)
      4'd0:    val = 22'sd184320;
      4'd1:    val = 22'sd108810;
      4'd2:    val = 22'sd57492;
      4'd3:    val = 22'sd29184;
      4'd4:    val = 22'sd14648;
      4'd5:    val = 22'sd7331;
      4'd6:    val = 22'sd3666;
      4'd7:    val = 22'sd1833;
      4'd8:    val = 22'sd916;
      4'd9:    val = 22'sd458;
      4'd10:   val = 22'sd229;
      4'd11:   val = 22'sd114;
      4'd12:   val = 22'sd57;
      4'd13:   val = 22'sd28;
      4'd14:   val = 22'sd14;
      default: val = 22'sd7;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/cordic_stage.sv @@
// One registered CORDIC micro-rotation with a fixed shift.
module cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  cordic_pkg::cordic_word_t in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output cordic_pkg::cordic_word_t out_word_o
);

  logic                                valid_q;
  cordic_pkg::cordic_word_t            word_q, word_d;
  logic                                rot_pos;
  logic signed [cordic_pkg::XY_W-1:0]  xs, ys;
  logic signed [cordic_pkg::ANG_W-1:0] step_ang;

  // hold only when this stage has a word the next one refuses
  assign in_stall_o = valid_q && out_stall_i;

  // direction and one add/sub step
  always_comb begin
    if (in_word_i.cmd == cordic_pkg::CMD_ATAN) begin
      rot_pos = in_word_i.y[cordic_pkg::XY_W-1];
    end else begin
      rot_pos = !in_word_i.ang[cordic_pkg::ANG_W-1] && (in_word_i.ang != '0);
    end
    xs       = $signed(in_word_i.x) >>> STAGE;
    ys       = $signed(in_word_i.y) >>> STAGE;
    step_ang = cordic_pkg::atan_q12(cordic_pkg::TAB_W'(STAGE));
    word_d.cmd = in_word_i.cmd;
    if (rot_pos) begin
      word_d.x   = in_word_i.x - ys;
      word_d.y   = in_word_i.y + xs;
      word_d.ang = in_word_i.ang - step_ang;
    end else begin
      word_d.x   = in_word_i.x + ys;
      word_d.y   = in_word_i.y - xs;
      word_d.ang = in_word_i.ang + step_ang;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

@@ hdl/cordic_scale.sv @@
// Output stage: gain multiply for sine/cosine, angle select, result register.
module cordic_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cordic_pkg::cordic_word_t            in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cordic_pkg::RES_W-1:0] result_o
);

  logic                                 valid_q;
  logic signed [cordic_pkg::RES_W-1:0]  result_q, result_d;
  logic signed [cordic_pkg::XY_W-1:0]   sel;
  logic signed [cordic_pkg::PROD_W-1:0] prod;
  logic signed [cordic_pkg::PROD_W-1:0] prod_sh;

  assign in_stall_o = valid_q && out_stall_i;

  // scale y or x by the gain, floor via arithmetic shift
  always_comb begin
    sel     = (in_word_i.cmd == cordic_pkg::CMD_SIN) ? in_word_i.y : in_word_i.x;
    prod    = cordic_pkg::PROD_W'(sel) * cordic_pkg::PROD_W'(cordic_pkg::GAIN_Q12);
    prod_sh = prod >>> cordic_pkg::FRAC_W;
    unique case (in_word_i.cmd)
      cordic_pkg::CMD_SIN,
      cordic_pkg::CMD_COS:    result_d = prod_sh[cordic_pkg::RES_W-1:0];
      cordic_pkg::CMD_ROTATE,
      cordic_pkg::CMD_ATAN:   result_d = in_word_i.ang;
      default:                result_d = in_word_i.ang;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ hdl/cordic_sin_cos_arctan_unit.sv @@
// Top level: pipelined circular CORDIC for sine, cosine, arctangent and rotation.
// The unit takes one word per cycle unless in_stall_o holds it back. It has one
// register stage per CORDIC iteration (a shift-add on x and y and a table add on
// the angle), N stages where N is ITERATIONS limited to the 16 table entries,
// then one stage for the 2487/4096 gain multiply and result select. A stall on
// the output holds only stages that carry a word; empty stages still fill, so the
// pipeline also absorbs words while the output waits.
module cordic_sin_cos_arctan_unit #(
  parameter int ITERATIONS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          cmd_i,
  input  logic signed [cordic_pkg::IN_W-1:0]  x_in_i,
  input  logic signed [cordic_pkg::IN_W-1:0]  y_in_i,
  input  logic signed [cordic_pkg::AIN_W-1:0] angle_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cordic_pkg::RES_W-1:0] result_o
);

  // iteration count limited to the table
  localparam int N_STAGES = (ITERATIONS > cordic_pkg::TAB_LEN) ? cordic_pkg::TAB_LEN
                                                                : ITERATIONS;

  cordic_pkg::cordic_word_t word  [N_STAGES+1];
  logic                     valid [N_STAGES+1];
  logic                     stall [N_STAGES+1];

  // widen the input word
  assign word[0].cmd = cordic_pkg::cmd_e'(cmd_i);
  assign word[0].x   = cordic_pkg::XY_W'(x_in_i);
  assign word[0].y   = cordic_pkg::XY_W'(y_in_i);
  assign word[0].ang = cordic_pkg::ANG_W'(angle_in_i);
  assign valid[0]    = in_valid_i;
  assign in_stall_o  = stall[0];

  // one stage per iteration
  for (genvar g = 0; g < N_STAGES; g++) begin : g_stage
    cordic_stage #(
      .STAGE (g)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[g]),
      .in_stall_o  (stall[g]),
      .in_word_i   (word[g]),
      .out_valid_o (valid[g+1]),
      .out_stall_i (stall[g+1]),
      .out_word_o  (word[g+1])
    );
  end

  // gain and result select
  cordic_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid[N_STAGES]),
    .in_stall_o  (stall[N_STAGES]),
    .in_word_i   (word[N_STAGES]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o)
  );

endmodule

@@ hdl/cordic_checker.sv @@
// Port-level checker for the CORDIC unit, bound to the top level.
`include "assert_macros.svh"

module cordic_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [1:0]                          cmd_i,
  input logic signed [cordic_pkg::IN_W-1:0]  x_in_i,
  input logic signed [cordic_pkg::IN_W-1:0]  y_in_i,
  input logic signed [cordic_pkg::AIN_W-1:0] angle_in_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [cordic_pkg::RES_W-1:0] result_o
);

  // pipeline holds no word while in reset
  `CORDIC_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  // input is held back only when the output is held back
  `CORDIC_ASSERT(a_stall_origin, clk_i, rst_ni, in_stall_o |-> out_stall_i)

  // a refused result stays put
  `CORDIC_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o))

  // a stalled input word stays put
  `CORDIC_ASSERT(a_in_hold, clk_i, rst_ni,
    in_valid_i && in_stall_o |=> in_valid_i && $stable(cmd_i) && $stable(x_in_i) && $stable(y_in_i) && $stable(angle_in_i))

endmodule

bind cordic_sin_cos_arctan_unit cordic_checker u_checker (.*);

@@ sim/tb_top.sv @@
// Testbench for the pipelined CORDIC unit: random and directed words, scoreboard check.
`timescale 1ns / 100ps

// Scoreboard: predicts each result from the accepted input word and checks it in order
class cordic_scoreboard;
  typedef struct {
    cordic_pkg::cmd_e                    cmd;
    logic signed [cordic_pkg::RES_W-1:0] value;
  } expected_t;

  expected_t expected_q[$];
  int        n_iter;
  int        errors;
  int        n_checked;
  int        n_per_cmd[4];
  longint    micro_angle[16];

  function new(int iterations);
    n_iter = (iterations > 16) ? 16 : iterations;
    errors = 0;
    n_checked = 0;
    foreach (n_per_cmd[k]) n_per_cmd[k] = 0;
    micro_angle = '{184320, 108810, 57492, 29184, 14648, 7331, 3666, 1833,
                    916, 458, 229, 114, 57, 28, 14, 7};
  endfunction

  // Shift-add iterations, then gain scaling or angle select
  function logic signed [cordic_pkg::RES_W-1:0] compute_result(
      cordic_pkg::cmd_e cmd, logic signed [cordic_pkg::IN_W-1:0] xi,
      logic signed [cordic_pkg::IN_W-1:0] yi, logic signed [cordic_pkg::AIN_W-1:0] ai);
    longint xv, yv, av, xs, ys, rv;
    bit     turn_neg;
    xv = xi;
    yv = yi;
    av = ai;
    for (int k = 0; k < n_iter; k++) begin
      turn_neg = (cmd == cordic_pkg::CMD_ATAN) ? (yv < 0) : (av > 0);
      xs = xv >>> k;
      ys = yv >>> k;
      if (turn_neg) begin
        xv = xv - ys;
        yv = yv + xs;
        av = av - micro_angle[k];
      end else begin
        xv = xv + ys;
        yv = yv - xs;
        av = av + micro_angle[k];
      end
    end
    case (cmd)
      cordic_pkg::CMD_SIN: rv = (yv * longint'(cordic_pkg::GAIN_Q12)) >>> cordic_pkg::FRAC_W;
      cordic_pkg::CMD_COS: rv = (xv * longint'(cordic_pkg::GAIN_Q12)) >>> cordic_pkg::FRAC_W;
      default:             rv = av;
    endcase
    return rv[cordic_pkg::RES_W-1:0];
  endfunction

  function void note_input(cordic_pkg::cmd_e cmd, logic signed [cordic_pkg::IN_W-1:0] xi,
                           logic signed [cordic_pkg::IN_W-1:0] yi,
                           logic signed [cordic_pkg::AIN_W-1:0] ai);
    expected_t e;
    e.cmd = cmd;
    e.value = compute_result(cmd, xi, yi, ai);
    expected_q.push_back(e);
    n_per_cmd[cmd]++;
  endfunction

  task report(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  task check_result(logic signed [cordic_pkg::RES_W-1:0] got);
    expected_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result %0d", got));
    end else begin
      e = expected_q.pop_front();
      n_checked++;
      if (got !== e.value)
        report($sformatf("%s result got %0d exp %0d", e.cmd.name(), got, e.value));
    end
  endtask

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  localparam int ITERATIONS = 16;
  localparam int N_RANDOM   = 1550;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = ITERATIONS + 21;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic [1:0]                          cmd_i;
  logic signed [cordic_pkg::IN_W-1:0]  x_in_i;
  logic signed [cordic_pkg::IN_W-1:0]  y_in_i;
  logic signed [cordic_pkg::AIN_W-1:0] angle_in_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [cordic_pkg::RES_W-1:0] result_o;

  cordic_scoreboard sb;
  int  out_hold;
  bit  burst_mode;
  int  idle_cycles;

  cordic_sin_cos_arctan_unit #(.ITERATIONS(ITERATIONS)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .x_in_i     (x_in_i),
    .y_in_i     (y_in_i),
    .angle_in_i (angle_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_o)
  );

  // Clock, 20 ns period
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Gap drawn per word, none in burst stretches
  function int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 19);
  endfunction

  // Present one input word and hold it until accepted
  task send_word(cordic_pkg::cmd_e cmd, logic signed [cordic_pkg::IN_W-1:0] xi,
                 logic signed [cordic_pkg::IN_W-1:0] yi,
                 logic signed [cordic_pkg::AIN_W-1:0] ai);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    x_in_i     <= xi;
    y_in_i     <= yi;
    angle_in_i <= ai;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_input(cmd, xi, yi, ai);
  endtask

  // Coordinate: mostly full range, some small values and extremes
  function logic signed [cordic_pkg::IN_W-1:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return cordic_pkg::IN_W'($urandom());
    if (sel < 85) return cordic_pkg::IN_W'(int'($urandom_range(0, 128)) - 64);
    case ($urandom_range(0, 4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return -16'sd1;
    endcase
  endfunction

  // Angle: mostly within +-180 degrees, some near zero and some edges
  function logic signed [cordic_pkg::AIN_W-1:0] rand_angle();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return cordic_pkg::AIN_W'(int'($urandom_range(0, 1474560)) - 737280);
    if (sel < 85) return cordic_pkg::AIN_W'(int'($urandom_range(0, 32)) - 16);
    case ($urandom_range(0, 5))
      0: return 21'sd737280;
      1: return -21'sd737280;
      2: return 21'sd0;
      3: return 21'sd184320;
      4: return -21'sd368640;
      default: return 21'sd368640;
    endcase
  endfunction

  // Output side: stall drawn after each result, released at the falling edge
  initial begin
    out_stall_i = 1'b0;
    out_hold = 0;
    forever begin
      @(negedge clk_i);
      if (out_hold > 0) begin
        out_stall_i <= 1'b1;
        out_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result monitor
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        sb.check_result(result_o);
        out_hold = burst_mode ? 0 : $urandom_range(0, 19);
      end
    end
  end

  // Watchdog on cycles without any accepted word
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
        idle_cycles = 0;
      else if (rst_ni)
        idle_cycles++;
    end
    $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    sb = new(ITERATIONS);
    burst_mode = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    cmd_i      = cordic_pkg::CMD_ROTATE;
    x_in_i     = '0;
    y_in_i     = '0;
    angle_in_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, each command, zero angle, y of zero in vectoring,
    // and angles beyond +-180 degrees
    send_word(cordic_pkg::CMD_ROTATE, 16'sd4096, 16'sd0, 21'sd0);
    send_word(cordic_pkg::CMD_ROTATE, 16'sd0, 16'sd0, 21'sd737280);
    send_word(cordic_pkg::CMD_ROTATE, 16'sd0, 16'sd0, -21'sd737280);
    send_word(cordic_pkg::CMD_ROTATE, 16'sd0, 16'sd0, 21'sh0fffff);
    send_word(cordic_pkg::CMD_ROTATE, 16'sd0, 16'sd0, 21'sh100000);
    send_word(cordic_pkg::CMD_ATAN, 16'sd4096, 16'sd0, 21'sd0);
    send_word(cordic_pkg::CMD_ATAN, 16'sd4096, 16'sd4096, 21'sd0);
    send_word(cordic_pkg::CMD_ATAN, 16'sh7fff, 16'sh8000, 21'sd0);
    send_word(cordic_pkg::CMD_ATAN, 16'sh8000, 16'sh7fff, 21'sd737280);
    send_word(cordic_pkg::CMD_ATAN, -16'sd4096, -16'sd1, -21'sd737280);
    send_word(cordic_pkg::CMD_SIN, 16'sd4096, 16'sd0, 21'sd122880);
    send_word(cordic_pkg::CMD_SIN, 16'sh7fff, 16'sh7fff, 21'sd737280);
    send_word(cordic_pkg::CMD_SIN, 16'sh8000, 16'sh8000, -21'sd737280);
    send_word(cordic_pkg::CMD_SIN, 16'sd4096, 16'sd0, 21'sd0);
    send_word(cordic_pkg::CMD_SIN, 16'sh7fff, 16'sd0, 21'sh100000);
    send_word(cordic_pkg::CMD_COS, 16'sd4096, 16'sd0, 21'sd245760);
    send_word(cordic_pkg::CMD_COS, 16'sh7fff, 16'sh8000, 21'sd0);
    send_word(cordic_pkg::CMD_COS, 16'sh8000, 16'sh7fff, 21'sd368640);
    send_word(cordic_pkg::CMD_COS, -16'sd1, -16'sd1, -21'sd1);
    send_word(cordic_pkg::CMD_COS, 16'sh8000, 16'sh8000, 21'sh0fffff);

    // Random words in stretches, some without any idling
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0)
        burst_mode = ($urandom_range(0, 2) == 0);
      send_word(cordic_pkg::cmd_e'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                rand_angle());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then allow for a word still in flight
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("checked %0d results: rotate %0d, atan %0d, sin %0d, cos %0d",
             sb.n_checked, sb.n_per_cmd[cordic_pkg::CMD_ROTATE],
             sb.n_per_cmd[cordic_pkg::CMD_ATAN], sb.n_per_cmd[cordic_pkg::CMD_SIN],
             sb.n_per_cmd[cordic_pkg::CMD_COS]);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
